/* sv/vector3_magnitude_normalize_assert.svh */
// Assertion macros for the vector normalizer.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef VECTOR3_MAGNITUDE_NORMALIZE_ASSERT_SVH
`define VECTOR3_MAGNITUDE_NORMALIZE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VMN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector normalizer check failed");

// Next-cycle implication, disabled during reset.
`define VMN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector normalizer check failed");

`endif

/* sv/vmn_pkg.sv */
// Shared types, constants and step functions of the vector normalizer.
// No dependencies.
package vmn_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int SQRT_STEPS  = 32;
  localparam int UNIT_BITS   = 17;
  localparam logic [16:0] UNIT_ONE = 17'h10000;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [63:0]      sum;
    logic [2:0][62:0] mag2;
    logic [2:0]       neg;
    logic             zero;
  } vmn_work_t;

  // State of one item inside the back pipeline.
  typedef struct packed {
    logic [63:0]      sum;
    logic [63:0]      rem;
    logic [63:0]      res;
    logic [2:0][94:0] rrem;
    logic [2:0][80:0] qs;
    logic [2:0][16:0] q;
    logic [2:0]       neg;
    logic             zero;
  } vmn_bstate_t;

  function automatic vmn_bstate_t vmn_init(input vmn_work_t w);
    vmn_bstate_t s;
    s.sum  = w.sum;
    s.rem  = w.sum;
    s.res  = '0;
    for (int i = 0; i < 3; i++) begin
      s.rrem[i] = {w.mag2[i], 32'b0};
      s.qs[i]   = '0;
      s.q[i]    = '0;
    end
    s.neg  = w.neg;
    s.zero = w.zero;
    return s;
  endfunction

  // One square-root digit, and for the first UNIT_BITS steps one quotient bit
  // per component. k is a constant per pipeline stage.
  function automatic vmn_bstate_t vmn_step(input vmn_bstate_t s, input int k);
    vmn_bstate_t n;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [99:0] dv;
    int          b;
    n     = s;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = s.res + bitv;
    if (s.rem >= trial) begin
      n.rem = s.rem - trial;
      n.res = (s.res >> 1) + bitv;
    end else begin
      n.res = s.res >> 1;
    end
    b = UNIT_BITS - 1 - k;
    if (k < UNIT_BITS) begin
      for (int i = 0; i < 3; i++) begin
        dv = ({19'b0, s.qs[i]} << (b + 1)) + ({36'b0, s.sum} << (2 * b));
        if (!s.q[i][16] && dv <= {5'b0, s.rrem[i]}) begin
          n.rrem[i] = s.rrem[i] - dv[94:0];
          n.qs[i]   = s.qs[i] + ({17'b0, s.sum} << b);
          n.q[i]    = s.q[i] | (17'd1 << b);
        end
      end
    end
    return n;
  endfunction

endpackage

/* sv/vmn_front.sv */
// Front part: takes signed components, splits magnitude and sign, squares, sums and flags zero vectors.
// Depends on vmn_pkg.
module vmn_front import vmn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      comp_x,
  input  logic [31:0]      comp_y,
  input  logic [31:0]      comp_z,
  input  logic             q_full,
  output logic             push,
  output vmn_work_t        push_data
);

  logic             a_valid, b_valid, c_valid;
  logic [2:0][31:0] a_mag;
  logic [2:0]       a_neg, b_neg;
  logic [2:0][62:0] b_sq;
  logic [2:0][31:0] comp;
  logic             adv;
  logic [63:0]      sum_next;

  assign comp     = {comp_z, comp_y, comp_x};
  assign adv      = !c_valid || !q_full;
  assign in_stall = !adv;
  assign push     = c_valid && !q_full;
  assign sum_next = {1'b0, b_sq[0]} + {1'b0, b_sq[1]} + {1'b0, b_sq[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= comp[i][31];
        a_mag[i] <= comp[i][31] ? 32'(-comp[i]) : comp[i];
        b_sq[i]  <= 63'({32'b0, a_mag[i]} * {32'b0, a_mag[i]});
      end
      b_neg          <= a_neg;
      push_data.mag2 <= b_sq;
      push_data.neg  <= b_neg;
      push_data.sum  <= sum_next;
      push_data.zero <= (sum_next == 64'd0);
    end
  end

endmodule

/* sv/vmn_queue.sv */
// Short FIFO between front and back.
// Depends on vmn_pkg.
module vmn_queue import vmn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vmn_work_t push_data,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output vmn_work_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vmn_work_t       entries [DEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_data;
  end

endmodule

/* sv/vmn_back.sv */
// Back part: pipelined square root and three restoring quotient searches.
// Depends on vmn_pkg.
module vmn_back import vmn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  vmn_work_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] length,
  output logic [17:0] unit_x,
  output logic [17:0] unit_y,
  output logic [17:0] unit_z,
  output logic        zero_vector
);

  vmn_bstate_t             st [SQRT_STEPS];
  logic [SQRT_STEPS-1:0]   st_valid;
  logic                    adv;
  logic [2:0][17:0]        unit_next;
  vmn_bstate_t             last;

  assign adv  = !out_valid || !out_stall;
  assign pop  = adv && !q_empty;
  assign last = st[SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      st_valid  <= {st_valid[SQRT_STEPS-2:0], !q_empty};
      out_valid <= st_valid[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) st[0] <= vmn_step(vmn_init(head), 0);
  end

  for (genvar k = 1; k < SQRT_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) st[k] <= vmn_step(st[k-1], k);
    end
  end

  // Apply sign; a zero vector gives zero components.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (last.zero) unit_next[i] = '0;
      else if (last.neg[i]) unit_next[i] = -{1'b0, last.q[i]};
      else unit_next[i] = {1'b0, last.q[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      length      <= last.res[31:0];
      unit_x      <= unit_next[0];
      unit_y      <= unit_next[1];
      unit_z      <= unit_next[2];
      zero_vector <= last.zero;
    end
  end

endmodule

/* sv/vector3_magnitude_normalize.sv */
// Vector normalizer: floor length and Q1.16 unit vector of a Q16.16 3-vector.
// Throughput one transfer per cycle unless the output stalls.
// The 32-stage square-root pipeline sets latency.
// Synchronous active-high reset empties all stages and the queue; data regs keep values.
// Depends on vmn_pkg, vmn_front, vmn_queue, vmn_back and the assertion header.
`include "vector3_magnitude_normalize_assert.svh"
module vector3_magnitude_normalize import vmn_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] comp_x,
  input  logic [31:0] comp_y,
  input  logic [31:0] comp_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] length,
  output logic [17:0] unit_x,
  output logic [17:0] unit_y,
  output logic [17:0] unit_z,
  output logic        zero_vector
);

  vmn_work_t push_data, head;
  logic      push, pop, q_full, q_empty;

  // Front: abs, square, sum; hold while the queue is full.
  vmn_front u_front (
    .clk, .rst, .in_valid, .in_stall, .comp_x, .comp_y, .comp_z,
    .q_full, .push, .push_data
  );

  // Queue decouples front stalls from output stalls.
  vmn_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst, .push, .push_data, .pop, .full(q_full), .empty(q_empty), .head
  );

  // Back: advance all stages whenever the output register is free.
  vmn_back u_back (
    .clk, .rst, .q_empty, .head, .pop, .out_valid, .out_stall,
    .length, .unit_x, .unit_y, .unit_z, .zero_vector
  );

  // A zero vector must come out with zero length and zero components.
  `VMN_ASSERT_NOW(a_zero_units, out_valid && zero_vector,
    length == 32'd0 && unit_x == 18'd0 && unit_y == 18'd0 && unit_z == 18'd0)
  // A nonzero vector has length at least one LSB.
  `VMN_ASSERT_NOW(a_nonzero_len, out_valid && !zero_vector, length != 32'd0)
  // A stalled result holds its length on the next cycle.
  `VMN_ASSERT_NEXT(a_hold_len, out_valid && out_stall, $stable(length))

endmodule

/* dv/tb_vector3_magnitude_normalize.sv */
// Self-checking testbench for the vector normalizer: floor length and Q1.16 unit vector.
// Depends only on the vector3_magnitude_normalize RTL; runs directed rows, then random vectors.
module tb_vector3_magnitude_normalize;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1030;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  // One expected result of the normalizer.
  typedef struct {
    logic [31:0] length;
    logic [17:0] ux;
    logic [17:0] uy;
    logic [17:0] uz;
    logic        zero;
  } norm_result_t;

  // Directed row: vector plus an optional typed-in result.
  typedef struct {
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  z;
    bit           typed;
    norm_result_t res;
  } vec_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] comp_x = '0;
  logic [31:0] comp_y = '0;
  logic [31:0] comp_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [31:0] length;
  logic [17:0] unit_x;
  logic [17:0] unit_y;
  logic [17:0] unit_z;
  logic        zero_vector;

  norm_result_t pending_norms[$];
  int           n_errors = 0;
  int           n_results = 0;
  int           n_zero_seen = 0;
  int           cycle_count = 0;
  bit           calm = 1'b0;   // no idling on either side while set

  vector3_magnitude_normalize dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .length(length), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .zero_vector(zero_vector)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: fail the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt_floor(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Largest q <= 1.0 with q^2 * sum <= mag^2 * 2^32, so q <= mag*2^16/sqrt(sum).
  function automatic logic [16:0] unit_magnitude(input logic [31:0] mag,
                                                 input logic [63:0] sum);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [16:0]  q;
    logic [16:0]  cand;
    rhs = {96'b0, mag} * {96'b0, mag};
    rhs = rhs << 32;
    q = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = q | (17'd1 << b);
      if (cand <= 17'h10000) begin
        lhs = {111'b0, cand} * {111'b0, cand} * {64'b0, sum};
        if (lhs <= rhs) q = cand;
      end
    end
    return q;
  endfunction

  function automatic norm_result_t normalize_vector(input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [31:0] z);
    norm_result_t r;
    logic [31:0]  c[3];
    logic [31:0]  m[3];
    logic [63:0]  sum;
    logic [17:0]  u[3];
    c[0] = x; c[1] = y; c[2] = z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i][31] ? (~c[i] + 32'd1) : c[i];   // 2^31 stays exact unsigned
      sum = sum + {32'b0, m[i]} * {32'b0, m[i]};
    end
    r.length = 32'(isqrt_floor(sum));
    r.zero = (sum == 0);
    for (int i = 0; i < 3; i++) begin
      if (sum == 0) u[i] = '0;
      else begin
        u[i] = {1'b0, unit_magnitude(m[i], sum)};
        if (c[i][31]) u[i] = ~u[i] + 18'd1;
      end
    end
    r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
    return r;
  endfunction

  // Result side: random stall, compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (pending_norms.size() == 0) begin
          $error("unexpected result transfer length=%h", length);
          n_errors = n_errors + 1;
        end else begin
          norm_result_t e;
          e = pending_norms.pop_front();
          if (zero_vector) n_zero_seen <= n_zero_seen + 1;
          if (length !== e.length) begin
            $error("length expected %h actual %h", e.length, length);
            n_errors = n_errors + 1;
          end
          if (unit_x !== e.ux) begin
            $error("unit_x expected %h actual %h", e.ux, unit_x);
            n_errors = n_errors + 1;
          end
          if (unit_y !== e.uy) begin
            $error("unit_y expected %h actual %h", e.uy, unit_y);
            n_errors = n_errors + 1;
          end
          if (unit_z !== e.uz) begin
            $error("unit_z expected %h actual %h", e.uz, unit_z);
            n_errors = n_errors + 1;
          end
          if (zero_vector !== e.zero) begin
            $error("zero_vector expected %b actual %b", e.zero, zero_vector);
            n_errors = n_errors + 1;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 11);
    end
  end

  // Present one vector and hold it until the transfer happens.
  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input norm_result_t exp_res);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    comp_x <= x;
    comp_y <= y;
    comp_z <= z;
    pending_norms.push_back(exp_res);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] random_component();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(255) - 128;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return 32'(int'($urandom_range(65535)) - 32768) << 8;
      4: return 0;
      default: return $urandom_range(1 << 20);
    endcase
  endfunction

  vec_row_t    directed[$];
  norm_result_t exp_res;
  logic [31:0] rx, ry, rz;

  function automatic vec_row_t row(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input bit typed,
                                   input logic [31:0] len, input logic [17:0] ux,
                                   input logic [17:0] uy, input logic [17:0] uz,
                                   input logic zv);
    vec_row_t r;
    r.x = x; r.y = y; r.z = z; r.typed = typed;
    r.res.length = len; r.res.ux = ux; r.res.uy = uy; r.res.uz = uz; r.res.zero = zv;
    return r;
  endfunction

  initial begin
    // Zero vector, single axes at the extremes and unit size, then mixed rows.
    directed.push_back(row(0, 0, 0, 1, 0, 0, 0, 0, 1));
    directed.push_back(row(32'h0001_0000, 0, 0, 1, 32'h0001_0000, 18'h10000, 0, 0, 0));
    directed.push_back(row(0, 32'hFFFF_0000, 0, 1, 32'h0001_0000, 0, 18'h30000, 0, 0));
    directed.push_back(row(0, 0, 32'h8000_0000, 1, 32'h8000_0000, 0, 0, 18'h30000, 0));
    directed.push_back(row(32'h7FFF_FFFF, 0, 0, 1, 32'h7FFF_FFFF, 18'h10000, 0, 0, 0));
    directed.push_back(row(0, 32'h0000_0001, 0, 1, 1, 0, 18'h10000, 0, 0));
    directed.push_back(row(0, 0, 32'hFFFF_FFFF, 1, 1, 0, 0, 18'h30000, 0));
    directed.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(1, 1, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      exp_res = directed[i].typed ? directed[i].res
              : normalize_vector(directed[i].x, directed[i].y, directed[i].z);
      send_vector(directed[i].x, directed[i].y, directed[i].z, exp_res);
    end

    // Hold off the sender until the pipeline has drained completely.
    in_valid <= 1'b0;
    while (pending_norms.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 300 && n < 450);   // back-to-back stretch with no idling
      rx = random_component();
      ry = random_component();
      rz = random_component();
      send_vector(rx, ry, rz, normalize_vector(rx, ry, rz));
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_norms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d normalized vectors (%0d zero vectors), %0d directed rows.",
             n_results, n_zero_seen, directed.size());
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/vmn_pkg.sv
sv/vmn_front.sv
sv/vmn_queue.sv
sv/vmn_back.sv
sv/vector3_magnitude_normalize.sv
dv/tb_vector3_magnitude_normalize.sv
